FILE: rtl/trs_pkg.sv
// Shared types and constants for the timed relay start sequencer.
package trs_pkg;

	// Item commands.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Sequencer phases. Codes 6 and 7 are never reached.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CONFIRM = 3'd1,
		PH_SWITCH  = 3'd2,
		PH_LATCH   = 3'd3,
		PH_RELEASE = 3'd4,
		PH_REARM   = 3'd5
	} phase_t;

	// Delay register indexes.
	typedef enum logic [2:0] {
		DLY_CONFIRM = 3'd0,
		DLY_STABLE  = 3'd1,
		DLY_ON      = 3'd2,
		DLY_LATCH   = 3'd3,
		DLY_OFF     = 3'd4,
		DLY_HOLDOFF = 3'd5
	} delay_sel_t;

	localparam int          DELAY_W    = 16;
	localparam logic [2:0]  NUM_DELAYS = 3'd6;

	typedef logic [DELAY_W-1:0] delay_t;

	localparam delay_t RST_CONFIRM = 16'd5;
	localparam delay_t RST_STABLE  = 16'd5;
	localparam delay_t RST_ON      = 16'd5;
	localparam delay_t RST_LATCH   = 16'd5;
	localparam delay_t RST_OFF     = 16'd10;
	localparam delay_t RST_HOLDOFF = 16'd360;

	// Relay level bit positions.
	localparam int RLY_TOR1 = 0;
	localparam int RLY_TOR2 = 1;
	localparam int RLY_OUT1 = 2;
	localparam int RLY_OUT2 = 3;
	localparam int RLY_OUT3 = 4;

	typedef logic [4:0] relay_t;
	localparam relay_t RELAYS_OFF     = 5'b00000;
	localparam relay_t RELAYS_ALL     = 5'b11111;
	localparam relay_t RELAYS_KEEP3   = 5'b10000;

	// LED drive bit positions: bit 0 first, bit 1 second, bit 2 third.
	typedef logic [2:0] led_t;
	localparam led_t LEDS_OFF    = 3'b000;
	localparam led_t LEDS_SECOND = 3'b010;
	localparam led_t LEDS_THIRD  = 3'b100;

	// Request from the sequencer to the countdown timer.
	typedef struct packed {
		logic       tick;
		logic       load;
		delay_sel_t sel;
	} timer_ctrl_t;

endpackage

FILE: rtl/trs_timer.sv
// One-shot countdown timer: decrements on ticks, flags done one tick after zero.
module trs_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  trs_pkg::timer_ctrl_t ctrl,
	input  trs_pkg::delay_t     load_value,
	output logic                done,
	output logic                done_next,
	output logic                running
);
	import trs_pkg::*;

	delay_t count_q, count_d;
	logic   running_q, running_d;
	logic   done_q, done_d;

	always_comb begin
		count_d   = count_q;
		running_d = running_q;
		done_d    = done_q;
		if (ctrl.load) begin
			count_d   = load_value;
			running_d = 1'b1;
			done_d    = 1'b0;
		end else if (ctrl.tick && running_q) begin
			if (count_q != '0) begin
				count_d = count_q - delay_t'(1);
			end else begin
				done_d    = 1'b1;
				running_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= 1'b0;
			done_q    <= 1'b1;
		end else begin
			count_q   <= count_d;
			running_q <= running_d;
			done_q    <= done_d;
		end
	end

	assign done      = done_q;
	assign done_next = done_d;
	assign running   = running_q;

endmodule

FILE: rtl/trs_seq.sv
// Phase sequencer: steps relay and LED levels and requests timer reloads.
module trs_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic                 cmd,
	input  logic                 pin_low,
	input  logic                 timer_done,
	output trs_pkg::timer_ctrl_t ctrl,
	output trs_pkg::phase_t      phase_q,
	output trs_pkg::phase_t      phase_next,
	output trs_pkg::relay_t      relay_next,
	output trs_pkg::led_t        led_next
);
	import trs_pkg::*;

	phase_t phase_d;
	relay_t relay_q, relay_d;
	led_t   led_q, led_d;
	logic   eval_en;

	assign eval_en = step_en && (cmd == CMD_EVAL) && timer_done;

	always_comb begin
		phase_d   = phase_q;
		relay_d   = relay_q;
		led_d     = led_q;
		ctrl.tick = step_en && (cmd == CMD_TICK);
		ctrl.load = 1'b0;
		ctrl.sel  = DLY_CONFIRM;
		if (eval_en) begin
			case (phase_q)
				PH_IDLE: begin
					relay_d[RLY_OUT3] = 1'b0;
					if (pin_low) begin
						phase_d   = PH_CONFIRM;
						ctrl.load = 1'b1;
						ctrl.sel  = DLY_CONFIRM;
					end
				end
				PH_CONFIRM: begin
					if (pin_low) begin
						led_d     = LEDS_SECOND;
						phase_d   = PH_SWITCH;
						ctrl.load = 1'b1;
						ctrl.sel  = DLY_STABLE;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_SWITCH: begin
					if (pin_low) begin
						led_d     = LEDS_THIRD;
						relay_d   = RELAYS_ALL;
						phase_d   = PH_LATCH;
						ctrl.load = 1'b1;
						ctrl.sel  = DLY_ON;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_LATCH: begin
					phase_d   = PH_RELEASE;
					ctrl.load = 1'b1;
					ctrl.sel  = DLY_LATCH;
				end
				PH_RELEASE: begin
					relay_d   = relay_q & RELAYS_KEEP3;
					phase_d   = PH_REARM;
					ctrl.load = 1'b1;
					ctrl.sel  = DLY_OFF;
				end
				PH_REARM: begin
					if (pin_low) begin
						phase_d = PH_SWITCH;
					end else begin
						phase_d   = PH_IDLE;
						ctrl.load = 1'b1;
						ctrl.sel  = DLY_HOLDOFF;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			relay_q <= RELAYS_OFF;
			led_q   <= LEDS_OFF;
		end else if (step_en) begin
			phase_q <= phase_d;
			relay_q <= relay_d;
			led_q   <= led_d;
		end
	end

	assign phase_next = phase_d;
	assign relay_next = relay_d;
	assign led_next   = led_d;

endmodule

FILE: rtl/timed_relay_start_sequencer.sv
// Top level of the timed relay start sequencer with input and result registers.
// Items pass the input register, then the result register; out_stall can hold either.
// Throughput: one item per cycle while out_stall is low; the state update for an item
// completes in the cycle it leaves the input register, so the next item sees it at once.
// Reset: arst_n clears phase, relays, LEDs, the timer (done set) and both pipeline valids,
// and returns the six delay registers to their default values.
module timed_relay_start_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic                  pin_low,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            phase,
	output logic                  timer_expired,
	output logic                  relay_tor1,
	output logic                  relay_tor2,
	output logic                  relay_out1,
	output logic                  relay_out2,
	output logic                  relay_out3,
	output logic                  led_first,
	output logic                  led_second,
	output logic                  led_third,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import trs_pkg::*;

	// Delay registers, written by index; indexes past the last register are dropped.
	delay_t delay_q [NUM_DELAYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q[DLY_CONFIRM] <= RST_CONFIRM;
			delay_q[DLY_STABLE]  <= RST_STABLE;
			delay_q[DLY_ON]      <= RST_ON;
			delay_q[DLY_LATCH]   <= RST_LATCH;
			delay_q[DLY_OFF]     <= RST_OFF;
			delay_q[DLY_HOLDOFF] <= RST_HOLDOFF;
		end else if (cfg_we && (cfg_index < NUM_DELAYS)) begin
			delay_q[cfg_index] <= cfg_data;
		end
	end

	// Input register stage. An item is applied to the state as it leaves this
	// register; it moves on whenever the result register is free.
	logic valid_s1, cmd_s1, pin_low_s1;
	logic advance;
	logic in_xfer;

	// The result register is free when empty or when its transfer completes now.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1     <= cmd;
			pin_low_s1 <= pin_low;
		end
	end

	// State update happens only when the item leaves the input register.
	logic        step_en;
	timer_ctrl_t tmr_ctrl;
	logic        tmr_done, tmr_done_next, tmr_running;
	phase_t      seq_phase_q, phase_next;
	relay_t      relay_next;
	led_t        led_next;

	assign step_en = valid_s1 && advance;

	trs_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.cmd        (cmd_s1),
		.pin_low    (pin_low_s1),
		.timer_done (tmr_done),
		.ctrl       (tmr_ctrl),
		.phase_q    (seq_phase_q),
		.phase_next (phase_next),
		.relay_next (relay_next),
		.led_next   (led_next)
	);

	trs_timer u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (tmr_ctrl),
		.load_value (delay_q[tmr_ctrl.sel]),
		.done       (tmr_done),
		.done_next  (tmr_done_next),
		.running    (tmr_running)
	);

	// Result register: captures the state as it stands after the item.
	logic   out_valid_q;
	phase_t phase_q;
	logic   expired_q;
	relay_t relay_q;
	led_t   led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			phase_q   <= phase_next;
			expired_q <= tmr_done_next;
			relay_q   <= relay_next;
			led_q     <= led_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign phase         = phase_q;
	assign timer_expired = expired_q;
	assign relay_tor1    = relay_q[RLY_TOR1];
	assign relay_tor2    = relay_q[RLY_TOR2];
	assign relay_out1    = relay_q[RLY_OUT1];
	assign relay_out2    = relay_q[RLY_OUT2];
	assign relay_out3    = relay_q[RLY_OUT3];
	assign led_first     = led_q[0];
	assign led_second    = led_q[1];
	assign led_third     = led_q[2];

	// The timer is never running and done at the same time.
	assert property (@(posedge clk) disable iff (!arst_n) !(tmr_running && tmr_done))
		else $error("timer running while done");

	// An evaluation while the timer is still counting leaves the phase alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (cmd_s1 == CMD_EVAL) && !tmr_done |=> $stable(seq_phase_q))
		else $error("phase moved before timer expired");

	// A reload is only requested once the previous countdown has finished.
	assert property (@(posedge clk) disable iff (!arst_n) tmr_ctrl.load |-> tmr_done)
		else $error("timer reloaded while counting");

	// At most one LED drive bit is ever set.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(led_next))
		else $error("more than one LED bit set");

endmodule
